// File: rtl/core/spva_pkg.sv
// Package for the via/avoid shortest-path block: sizes, command and status codes.
// No dependencies.
package spva_pkg;
   localparam int NODE_COUNT    = 64;
   localparam int EDGE_CAPACITY = 256;
   localparam int COST_BITS     = 16;
   localparam int NODE_W = $clog2(NODE_COUNT);
   localparam int EIDX_W = $clog2(EDGE_CAPACITY);
   localparam int ECNT_W = $clog2(EDGE_CAPACITY + 1);
   localparam int DIST_W = COST_BITS + NODE_W + 1;
   localparam int ROUTE_W = 24;
   localparam int NODE_F_W = 6;
   localparam int COST_F_W = 16;
   localparam logic [ROUTE_W-1:0] ROUTE_MAX = '1;

   typedef enum logic [1:0] {
      CMD_ADD = 2'd0, CMD_QUERY = 2'd1, CMD_CLEAR = 2'd2, CMD_NONE = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK = 2'd0, ST_UNREACH = 2'd1, ST_FULL = 2'd2
   } status_type;

   typedef struct packed {
      logic [1:0]          cmd;
      logic [NODE_F_W-1:0] node_a;
      logic [NODE_F_W-1:0] node_b;
      logic [COST_F_W-1:0] edge_cost;
      logic [NODE_F_W-1:0] via_node;
      logic [NODE_F_W-1:0] avoid_node;
   } req_type;

   typedef struct packed {
      logic [ROUTE_W-1:0] route_cost;
      logic [1:0]         status;
   } rsp_type;

   typedef struct packed {
      logic [NODE_W-1:0]    a;
      logic [NODE_W-1:0]    b;
      logic [COST_BITS-1:0] cost;
   } edge_type;

   // leg search control between top level and search engine
   typedef struct packed {
      logic              start;
      logic [NODE_W-1:0] src;
      logic [NODE_W-1:0] dst;
      logic [NODE_W-1:0] avoid;
   } leg_cmd_type;

   typedef struct packed {
      logic              done;
      logic              found;
      logic [DIST_W-1:0] cost;
   } leg_res_type;
endpackage

// File: rtl/core/spva_if.sv
// Valid/ready channel interface carrying one payload.
// Depends on spva_pkg for payload types.
interface spva_req_if (input logic clock);
   spva_pkg::req_type payload;
   logic valid;
   logic ready;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface spva_rsp_if (input logic clock);
   spva_pkg::rsp_type payload;
   logic valid;
   logic ready;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

// File: rtl/core/spva_leg.sv
// One Dijkstra leg by repeated minimum scans over a node distance memory.
// Depends on spva_pkg; reads the edge memory through a registered read port.
module spva_leg (
   input  logic                   clock,
   input  logic                   reset,
   input  spva_pkg::leg_cmd_type  leg_cmd,
   output spva_pkg::leg_res_type  leg_res,
   input  logic [spva_pkg::ECNT_W-1:0] edge_count,
   output logic [spva_pkg::EIDX_W-1:0] edge_addr,
   input  spva_pkg::edge_type     edge_data
);
   import spva_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE, S_INIT, S_SCAN, S_PICK, S_RELAX, S_FINAL, S_DONE
   } state_type;

   // per-node distance memory; reached/settled as flip-flop flags
   logic [DIST_W-1:0] dist_mem [NODE_COUNT];
   logic [DIST_W-1:0] dist_rd;
   logic [NODE_W-1:0] dist_raddr;
   logic              dist_we;
   logic [NODE_W-1:0] dist_waddr;
   logic [DIST_W-1:0] dist_wdata;

   logic [NODE_COUNT-1:0] reached_ff, settled_ff;
   state_type         state_ff;
   logic [NODE_W-1:0] src_ff, dst_ff, avoid_ff;
   logic [NODE_W:0]   scan_ff;          // scan counter incl. one flush step
   logic              scan_v_ff;        // previous read is a candidate
   logic [NODE_W-1:0] scan_n_ff;
   logic              best_v_ff;
   logic [NODE_W-1:0] best_ff;
   logic [DIST_W-1:0] best_d_ff;
   logic [ECNT_W-1:0] eidx_ff;
   logic              e_v_ff;
   logic [DIST_W-1:0] other_d_ff;      // write forwarded into the next read
   logic              fwd_v_ff;
   logic              other_v_ff;
   logic [NODE_W-1:0] other_ff;
   logic [DIST_W-1:0] nd_ff;
   logic              done_ff, found_ff;
   logic [DIST_W-1:0] cost_ff;

   // relax stage 1: edge data valid -> compute neighbor
   logic [NODE_W-1:0] nb;
   logic              nb_hit;
   always_comb begin
      nb = edge_data.b;
      nb_hit = 1'b0;
      if (edge_data.a == best_ff) begin
         nb = edge_data.b; nb_hit = 1'b1;
      end else if (edge_data.b == best_ff) begin
         nb = edge_data.a; nb_hit = 1'b1;
      end
      if (nb == avoid_ff) nb_hit = 1'b0;
   end

   assign edge_addr = eidx_ff[EIDX_W-1:0];

   always_comb begin
      dist_raddr = scan_ff[NODE_W-1:0];
      if (state_ff == S_RELAX) dist_raddr = nb;
      if (state_ff == S_FINAL) dist_raddr = dst_ff;
   end

   // second relax stage compares and writes; a write to the node read in
   // the same cycle is forwarded
   logic [DIST_W-1:0] od_cur;
   always_comb begin
      od_cur = fwd_v_ff ? other_d_ff : dist_rd;
      dist_we = 1'b0;
      dist_waddr = other_ff;
      dist_wdata = nd_ff;
      if (state_ff == S_INIT) begin
         dist_we = 1'b1; dist_waddr = src_ff; dist_wdata = '0;
      end else if (other_v_ff &&
                   (!reached_ff[other_ff] || nd_ff < od_cur)) begin
         dist_we = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      dist_rd <= dist_mem[dist_raddr];
      if (dist_we) dist_mem[dist_waddr] <= dist_wdata;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         done_ff <= 1'b0;
         reached_ff <= '0;
         settled_ff <= '0;
         e_v_ff <= 1'b0;
         other_v_ff <= 1'b0;
         fwd_v_ff <= 1'b0;
         scan_v_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         unique case (state_ff)
            S_IDLE: begin
               if (leg_cmd.start) begin
                  src_ff <= leg_cmd.src;
                  dst_ff <= leg_cmd.dst;
                  avoid_ff <= leg_cmd.avoid;
                  reached_ff <= '0;
                  settled_ff <= '0;
                  state_ff <= S_INIT;
               end
            end
            S_INIT: begin
               reached_ff[src_ff] <= 1'b1;
               scan_ff <= '0;
               scan_v_ff <= 1'b0;
               best_v_ff <= 1'b0;
               state_ff <= S_SCAN;
            end
            S_SCAN: begin
               if (scan_v_ff && (!best_v_ff || dist_rd < best_d_ff)) begin
                  best_v_ff <= 1'b1;
                  best_ff <= scan_n_ff;
                  best_d_ff <= dist_rd;
               end
               scan_n_ff <= scan_ff[NODE_W-1:0];
               scan_v_ff <= (scan_ff < (NODE_W+1)'(NODE_COUNT)) &&
                            reached_ff[scan_ff[NODE_W-1:0]] &&
                            !settled_ff[scan_ff[NODE_W-1:0]];
               if (scan_ff == (NODE_W+1)'(NODE_COUNT)) state_ff <= S_PICK;
               else scan_ff <= scan_ff + 1'b1;
            end
            S_PICK: begin
               if (!best_v_ff) begin
                  state_ff <= S_FINAL;
               end else begin
                  settled_ff[best_ff] <= 1'b1;
                  eidx_ff <= '0;
                  e_v_ff <= 1'b0;
                  other_v_ff <= 1'b0;
                  fwd_v_ff <= 1'b0;
                  state_ff <= S_RELAX;
               end
            end
            S_RELAX: begin
               // stage A: issue edge read; stage B: neighbor dist read;
               // stage C: compare/write
               if (eidx_ff < edge_count) begin
                  eidx_ff <= eidx_ff + 1'b1;
                  e_v_ff <= 1'b1;
               end else begin
                  e_v_ff <= 1'b0;
               end
               other_v_ff <= e_v_ff && nb_hit;
               other_ff <= nb;
               nd_ff <= best_d_ff + DIST_W'(edge_data.cost);
               if (dist_we && other_v_ff) reached_ff[other_ff] <= 1'b1;
               fwd_v_ff <= dist_we && (dist_waddr == nb);
               other_d_ff <= dist_wdata;
               if (!e_v_ff && !other_v_ff && !(eidx_ff < edge_count)) begin
                  scan_ff <= '0;
                  scan_v_ff <= 1'b0;
                  best_v_ff <= 1'b0;
                  state_ff <= S_SCAN;
               end
            end
            S_FINAL: begin
               state_ff <= S_DONE;
            end
            S_DONE: begin
               done_ff <= 1'b1;
               found_ff <= reached_ff[dst_ff];
               cost_ff <= dist_rd;
               state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign leg_res.done  = done_ff;
   assign leg_res.found = found_ff;
   assign leg_res.cost  = cost_ff;
endmodule

// File: rtl/core/shortest_path_via_avoid_node.sv
// Top level: edge memory, command decode, two-leg sequencing, response register.
// Depends on spva_pkg, spva_if and spva_leg.
// One transfer in, one transfer out per command. Edge add, clear and the
// unused command offer their result the cycle after the input transfer. A
// query that names the avoided node as an end or via node does the same with
// an unreachable status; any other query runs up to two Dijkstra legs in the
// search engine, and for each settled node a leg scans the distance memory
// and then makes a relax pass over the edge memory read port, for all stored
// edges. A new input is taken only once the previous result has been
// transferred.
// No clearing pass is needed after reset.
module shortest_path_via_avoid_node (
   input logic     clock,
   input logic     reset,
   spva_req_if.sink   req,
   spva_rsp_if.source rsp
);
   import spva_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE, S_LEG1, S_WAIT1, S_LEG2, S_WAIT2, S_RESP
   } state_type;

   edge_type          edge_mem [EDGE_CAPACITY];
   edge_type          edge_rd;
   logic [EIDX_W-1:0] edge_addr;
   logic              edge_we;

   state_type         state_ff;
   logic [ECNT_W-1:0] count_ff;
   req_type           q_ff;
   logic              rsp_valid_ff;
   rsp_type           rsp_ff;
   logic [DIST_W-1:0] c1_ff;
   leg_cmd_type       leg_cmd;
   leg_res_type       leg_res;

   logic accept;
   assign req.ready = (state_ff == S_IDLE) && !rsp_valid_ff;
   assign accept = req.valid && req.ready;
   assign edge_we = accept && req.payload.cmd == CMD_ADD &&
                    count_ff < ECNT_W'(EDGE_CAPACITY);

   always_ff @(posedge clock) begin
      edge_rd <= edge_mem[edge_addr];
      if (edge_we)
         edge_mem[count_ff[EIDX_W-1:0]] <= '{a: req.payload.node_a[NODE_W-1:0],
            b: req.payload.node_b[NODE_W-1:0], cost: req.payload.edge_cost[COST_BITS-1:0]};
   end

   always_comb begin
      leg_cmd.start = (state_ff == S_LEG1) || (state_ff == S_LEG2);
      leg_cmd.avoid = q_ff.avoid_node[NODE_W-1:0];
      leg_cmd.src = q_ff.node_a[NODE_W-1:0];
      leg_cmd.dst = q_ff.via_node[NODE_W-1:0];
      if (state_ff == S_LEG2) begin
         leg_cmd.src = q_ff.via_node[NODE_W-1:0];
         leg_cmd.dst = q_ff.node_b[NODE_W-1:0];
      end
   end

   spva_leg u_leg (
      .clock(clock), .reset(reset), .leg_cmd(leg_cmd), .leg_res(leg_res),
      .edge_count(count_ff), .edge_addr(edge_addr), .edge_data(edge_rd)
   );

   logic [DIST_W:0] total;
   assign total = {1'b0, c1_ff} + {1'b0, leg_res.cost};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp.ready) rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  q_ff <= req.payload;
                  case (req.payload.cmd)
                     CMD_ADD: begin
                        if (count_ff < ECNT_W'(EDGE_CAPACITY)) begin
                           count_ff <= count_ff + 1'b1;
                           rsp_ff <= '{route_cost: '0, status: ST_OK};
                        end else begin
                           rsp_ff <= '{route_cost: '0, status: ST_FULL};
                        end
                        rsp_valid_ff <= 1'b1;
                     end
                     CMD_CLEAR: begin
                        count_ff <= '0;
                        rsp_ff <= '{route_cost: '0, status: ST_OK};
                        rsp_valid_ff <= 1'b1;
                     end
                     CMD_QUERY: begin
                        if (req.payload.via_node == req.payload.avoid_node ||
                            req.payload.node_a == req.payload.avoid_node ||
                            req.payload.node_b == req.payload.avoid_node) begin
                           rsp_ff <= '{route_cost: '0, status: ST_UNREACH};
                           rsp_valid_ff <= 1'b1;
                        end else begin
                           rsp_ff <= '{route_cost: '0, status: ST_OK};
                           state_ff <= S_LEG1;
                        end
                     end
                     default: begin
                        rsp_ff <= '{route_cost: '0, status: ST_OK};
                        rsp_valid_ff <= 1'b1;
                     end
                  endcase
               end
            end
            S_LEG1: state_ff <= S_WAIT1;
            S_WAIT1: begin
               if (leg_res.done) begin
                  c1_ff <= leg_res.cost;
                  if (leg_res.found) state_ff <= S_LEG2;
                  else begin
                     rsp_ff.status <= ST_UNREACH;
                     state_ff <= S_RESP;
                  end
               end
            end
            S_LEG2: state_ff <= S_WAIT2;
            S_WAIT2: begin
               if (leg_res.done) begin
                  if (!leg_res.found) rsp_ff.status <= ST_UNREACH;
                  else if (total > (DIST_W+1)'(ROUTE_MAX)) rsp_ff.route_cost <= ROUTE_MAX;
                  else rsp_ff.route_cost <= total[ROUTE_W-1:0];
                  state_ff <= S_RESP;
               end
            end
            S_RESP: begin
               rsp_valid_ff <= 1'b1;
               state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp.valid = rsp_valid_ff;
   assign rsp.payload = rsp_ff;
endmodule

// File: rtl/core/spva_checker.sv
// Port-level checks for the shortest-path block, bound to the top level.
// Depends on spva_pkg.
module spva_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input spva_pkg::rsp_type rsp_payload
);
   import spva_pkg::*;

   a_one_outstanding: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready) else $error("input taken while result pending");

   a_cost_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.status != ST_OK |-> rsp_payload.route_cost == '0)
      else $error("nonzero cost with error status");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_payload.status != 2'd3) else $error("bad status");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("result dropped");

   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_ready |=> req_valid)
      else $error("request withdrawn");
endmodule

bind shortest_path_via_avoid_node spva_checker u_spva_checker (
   .clock(clock), .reset(reset), .req_valid(req.valid), .req_ready(req.ready),
   .rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp_payload(rsp.payload)
);

// File: test/spva_route_checker.sv
// Route checker: watches the request and response channels, predicts each response
// and compares it field by field. Depends on spva_pkg and the spva_if interfaces.
`timescale 1ns / 100ps

module spva_route_checker (
   input  logic clock,
   input  logic reset,
   spva_req_if  req_mon,
   spva_rsp_if  rsp_mon,
   output int   fail_count,
   output int   pending
);
   import spva_pkg::*;

   logic [NODE_W-1:0]    graph_a [EDGE_CAPACITY];
   logic [NODE_W-1:0]    graph_b [EDGE_CAPACITY];
   logic [COST_BITS-1:0] graph_w [EDGE_CAPACITY];
   int                   graph_edges;
   rsp_type              route_q [$];

   // one search leg that never enters the avoided node
   function automatic bit leg_cost(input int src, input int dst, input int avoid,
                                   output longint cost);
      longint node_dist [NODE_COUNT];
      bit     seen [NODE_COUNT];
      bit     done [NODE_COUNT];
      int     u;
      int     other;
      longint nd;
      cost = 0;
      for (int i = 0; i < NODE_COUNT; i++) begin
         node_dist[i] = 0;
         seen[i] = 0;
         done[i] = 0;
      end
      if (src == avoid) return 0;
      seen[src] = 1;
      while (1) begin
         u = -1;
         for (int i = 0; i < NODE_COUNT; i++)
            if (seen[i] && !done[i] && (u < 0 || node_dist[i] < node_dist[u])) u = i;
         if (u < 0) break;
         done[u] = 1;
         for (int e = 0; e < graph_edges; e++) begin
            if (int'(graph_a[e]) == u) other = int'(graph_b[e]);
            else if (int'(graph_b[e]) == u) other = int'(graph_a[e]);
            else continue;
            if (other == avoid) continue;
            nd = node_dist[u] + longint'(graph_w[e]);
            if (!seen[other] || nd < node_dist[other]) begin
               seen[other] = 1;
               node_dist[other] = nd;
            end
         end
      end
      if (!seen[dst]) return 0;
      cost = node_dist[dst];
      return 1;
   endfunction

   function automatic rsp_type predict_route(input req_type r);
      rsp_type res;
      longint  c1;
      longint  c2;
      longint  total;
      res.route_cost = '0;
      res.status = ST_OK;
      case (cmd_type'(r.cmd))
         CMD_ADD: begin
            if (graph_edges >= EDGE_CAPACITY) begin
               res.status = ST_FULL;
            end else begin
               graph_a[graph_edges] = r.node_a;
               graph_b[graph_edges] = r.node_b;
               graph_w[graph_edges] = r.edge_cost[COST_BITS-1:0];
               graph_edges++;
            end
         end
         CMD_QUERY: begin
            if (r.via_node == r.avoid_node || r.node_b == r.avoid_node ||
                r.node_a == r.avoid_node ||
                !leg_cost(int'(r.node_a), int'(r.via_node), int'(r.avoid_node), c1) ||
                !leg_cost(int'(r.via_node), int'(r.node_b), int'(r.avoid_node), c2)) begin
               res.status = ST_UNREACH;
            end else begin
               total = c1 + c2;
               res.route_cost = (total > ROUTE_MAX) ? ROUTE_MAX : total[ROUTE_W-1:0];
            end
         end
         CMD_CLEAR: graph_edges = 0;
         default: ;
      endcase
      return res;
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         graph_edges = 0;
         route_q.delete();
         fail_count = 0;
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (route_q.size() == 0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("unexpected transfer: cost %0d status %0d",
                           rsp_mon.payload.route_cost, rsp_mon.payload.status);
            end else begin
               want = route_q.pop_front();
               if (want.route_cost !== rsp_mon.payload.route_cost ||
                   want.status !== rsp_mon.payload.status) begin
                  fail_count++;
                  if (fail_count <= 10)
                     $display("mismatch: cost exp %0d got %0d, status exp %0d got %0d",
                              want.route_cost, rsp_mon.payload.route_cost,
                              want.status, rsp_mon.payload.status);
               end
            end
         end
         if (req_mon.valid && req_mon.ready)
            route_q.push_back(predict_route(req_mon.payload));
      end
      pending = route_q.size();
   end

   initial begin
      fail_count = 0;
      pending = 0;
      graph_edges = 0;
   end
endmodule

// File: test/tb_shortest_path_via_avoid_node.sv
// Testbench top: clock, reset, request stimulus, response back-pressure and verdict.
// Depends on spva_pkg, spva_if, the block and spva_route_checker.
`timescale 1ns / 100ps

module tb_shortest_path_via_avoid_node;
   import spva_pkg::*;

   logic clock;
   logic reset;
   int   fail_count;
   int   pending;
   bit   idle_on;
   int   hold_cycles;
   int   queries;
   int   adds;

   spva_req_if req (clock);
   spva_rsp_if rsp (clock);

   shortest_path_via_avoid_node dut (.clock(clock), .reset(reset), .req(req), .rsp(rsp));

   spva_route_checker checker_i (
      .clock(clock), .reset(reset), .req_mon(req), .rsp_mon(rsp),
      .fail_count(fail_count), .pending(pending)
   );

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   initial begin
      #50ms;
      $display("TB_ERROR");
      $finish;
   end

   // receiver back-pressure
   initial begin
      rsp.ready = 0;
      forever begin
         @(negedge clock);
         if (hold_cycles > 0) begin
            rsp.ready = 0;
            hold_cycles--;
         end else begin
            rsp.ready = idle_on ? ($urandom_range(99) >= 21) : 1'b1;
         end
      end
   end

   function automatic req_type make_req(input cmd_type c, input int a, input int b,
                                        input int w, input int via, input int avoid);
      req_type r;
      r.cmd = c;
      r.node_a = NODE_F_W'(a);
      r.node_b = NODE_F_W'(b);
      r.edge_cost = COST_F_W'(w);
      r.via_node = NODE_F_W'(via);
      r.avoid_node = NODE_F_W'(avoid);
      return r;
   endfunction

   task automatic send(input req_type r);
      while (idle_on && $urandom_range(99) < 21) begin
         req.valid = 0;
         @(negedge clock);
      end
      req.valid = 1;
      req.payload = r;
      if (r.cmd == CMD_QUERY) queries++;
      if (r.cmd == CMD_ADD) adds++;
      do @(posedge clock); while (!req.ready);
      @(negedge clock);
      req.valid = 0;
   endtask

   function automatic int pick_node();
      return ($urandom_range(99) < 90) ? $urandom_range(7) : $urandom_range(63);
   endfunction

   initial begin
      int live_edges;
      int pick;
      req.valid = 0;
      req.payload = '0;
      idle_on = 0;
      hold_cycles = 0;
      queries = 0;
      adds = 0;
      reset = 1;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 0;

      send(make_req(CMD_ADD, 0, 1, 5, 63, 0));
      send(make_req(CMD_ADD, 1, 2, 7, 0, 63));
      send(make_req(CMD_ADD, 0, 2, 20, 42, 21));
      send(make_req(CMD_ADD, 2, 3, 65535, 21, 42));
      send(make_req(CMD_ADD, 3, 3, 9, 0, 0));
      send(make_req(CMD_ADD, 1, 2, 7, 0, 0));
      send(make_req(CMD_ADD, 63, 62, 0, 63, 63));
      send(make_req(CMD_ADD, 4, 63, 65535, 0, 0));
      send(make_req(CMD_QUERY, 0, 3, 43690, 2, 10));
      send(make_req(CMD_QUERY, 0, 2, 21845, 1, 2));
      send(make_req(CMD_QUERY, 0, 3, 0, 2, 0));
      send(make_req(CMD_QUERY, 0, 3, 0, 2, 3));
      send(make_req(CMD_QUERY, 0, 2, 0, 0, 1));
      send(make_req(CMD_QUERY, 0, 0, 0, 0, 63));
      send(make_req(CMD_QUERY, 0, 63, 0, 1, 5));
      send(make_req(CMD_QUERY, 62, 4, 0, 63, 1));
      send(make_req(CMD_QUERY, 62, 4, 0, 63, 63));
      send(make_req(CMD_NONE, 63, 63, 65535, 63, 63));
      send(make_req(CMD_CLEAR, 0, 0, 0, 0, 0));
      send(make_req(CMD_QUERY, 0, 1, 0, 0, 5));

      // fill the edge table, starting while the receiver holds off
      hold_cycles = 400;
      for (int i = 0; i < EDGE_CAPACITY; i++)
         send(make_req(CMD_ADD, 5, 5, $urandom_range(65535), 0, 0));
      send(make_req(CMD_ADD, 1, 2, 3, 0, 0));
      send(make_req(CMD_QUERY, 5, 5, 0, 5, 6));
      send(make_req(CMD_CLEAR, 0, 0, 0, 0, 0));
      wait (pending == 0);

      live_edges = 0;
      for (int n = 0; n < 100; n++) begin
         if (n == 30) idle_on = 1;
         if (n == 60) wait (pending == 0);
         pick = $urandom_range(99);
         if (pick < 5 || live_edges > 40) begin
            send(make_req(CMD_CLEAR, $urandom_range(63), $urandom_range(63),
                          $urandom_range(65535), $urandom_range(63), $urandom_range(63)));
            live_edges = 0;
         end else if (pick < 55) begin
            send(make_req(CMD_ADD, pick_node(), pick_node(),
                          ($urandom_range(3) == 0) ? $urandom_range(65535) : $urandom_range(50),
                          $urandom_range(63), $urandom_range(63)));
            live_edges++;
         end else if (pick < 95) begin
            send(make_req(CMD_QUERY, pick_node(), pick_node(), $urandom_range(65535),
                          pick_node(), ($urandom_range(3) == 0) ? pick_node()
                                                                : $urandom_range(63)));
         end else begin
            send(make_req(CMD_NONE, $urandom_range(63), $urandom_range(63),
                          $urandom_range(65535), $urandom_range(63), $urandom_range(63)));
         end
      end

      wait (pending == 0);
      repeat (50) @(negedge clock);
      $display("covered %0d edge adds and %0d route queries, table full and clears",
               adds, queries);
      if (fail_count == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end
endmodule

// File: files.f
rtl/core/spva_pkg.sv
rtl/core/spva_if.sv
rtl/core/spva_leg.sv
rtl/core/shortest_path_via_avoid_node.sv
rtl/core/spva_checker.sv
test/spva_route_checker.sv
test/tb_shortest_path_via_avoid_node.sv
